FILE: rtl/core/gga_pkg.sv
// Package with the types and constants of the GGA position field extractor.
`default_nettype none

package gga_pkg;

   localparam int unsigned MAX_MESSAGE_BYTES_DEFAULT = 99;
   localparam int unsigned ID_CHARS                  = 5;
   localparam logic [39:0] SENTENCE_ID_RESET         = 40'h47_50_47_47_41;

   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_COMMA   = 8'h2c;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_NORTH   = 8'h4e;
   localparam logic [7:0] CHAR_SOUTH   = 8'h53;

   localparam logic [2:0] TOKEN_MAX       = 3'd7;
   localparam logic [2:0] TOKEN_LATITUDE  = 3'd2;
   localparam logic [2:0] TOKEN_LAT_HEMI  = 3'd3;
   localparam logic [2:0] TOKEN_LON_HEMI  = 3'd5;

   typedef enum logic [1:0] {
      PHASE_HUNT = 2'd0,
      PHASE_ID   = 2'd1,
      PHASE_MSG  = 2'd2
   } phase_type;

   typedef struct packed {
      logic       overflowed;
      logic       position_fixed;
      logic       end_of_sentence;
      logic [1:0] out_field;
      logic [7:0] out_byte;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/gga_position_field_extractor_top.sv
// Top level of the GGA position field extractor: parser state, result register and skid.
//
// The block takes one NMEA character per item on the req_ channel. It waits for '$',
// compares the sentence identifier up to the first comma with the five characters in
// the configuration register, and after a match counts comma separated tokens, runs
// of commas counting as one separator. Characters of latitude, its hemisphere,
// longitude and its hemisphere leave on the rsp_ channel tagged by field in rsp_tuser.
// A newline in a matched sentence yields an end item with rsp_tlast high that carries
// the fix flag and the overflow flag; all other characters yield no item.
// The item of an accepted character goes to the result register, or to the skid register
// while the receiver stalls. One character is accepted every cycle while req_tready is high,
// the parser state being updated in the cycle of acceptance. When the receiver stalls, one
// more item is caught in the skid register and req_tready drops only while it is full.
// Synchronous reset returns the parser to hunting for '$', empties the result and skid
// registers and loads the identifier "GPGGA". The identifier is to be written
// through csr_wr_en and csr_wr_data only while the block is idle; the block does not enforce this.
`default_nettype none

module gga_position_field_extractor_top #(
   parameter int unsigned MAX_MESSAGE_BYTES = gga_pkg::MAX_MESSAGE_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [39:0] csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [8] position_fixed, [9] overflowed
   output logic [1:0]       rsp_tuser,   // [1:0] out_field
   output logic             rsp_tlast    // end_of_sentence
);

   localparam int unsigned LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_MESSAGE_BYTES);

   logic [39:0]          sentence_id_ff;
   gga_pkg::phase_type   phase_ff, phase_in;
   logic [2:0]           id_pos_ff, id_pos_in;
   logic                 id_match_ff, id_match_in;
   logic                 after_sep_ff, after_sep_in;
   logic [2:0]           token_ff, token_in;
   logic [LEN_W-1:0]     msg_len_ff, msg_len_in;
   logic [1:0]           hemi_len_ff, hemi_len_in;
   logic                 hemi_valid_ff, hemi_valid_in;
   logic                 overflow_ff, overflow_in;

   gga_pkg::result_type  out_ff, out_in, skid_ff, skid_in, result;
   logic                 out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic                 result_valid;

   logic                 req_fire, rsp_fire;
   logic [7:0]           c;
   logic [7:0]           id_char;
   logic [2:0]           token_next;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = out_valid_ff && rsp_tready;
   assign c          = req_tdata;

   always_comb begin
      unique case (id_pos_ff)
         3'd0:    id_char = sentence_id_ff[39:32];
         3'd1:    id_char = sentence_id_ff[31:24];
         3'd2:    id_char = sentence_id_ff[23:16];
         3'd3:    id_char = sentence_id_ff[15:8];
         3'd4:    id_char = sentence_id_ff[7:0];
         default: id_char = 8'h00;
      endcase
   end

   // Next parser state and the result of the accepted character.
   always_comb begin
      phase_in      = phase_ff;
      id_pos_in     = id_pos_ff;
      id_match_in   = id_match_ff;
      after_sep_in  = after_sep_ff;
      token_in      = token_ff;
      msg_len_in    = msg_len_ff;
      hemi_len_in   = hemi_len_ff;
      hemi_valid_in = hemi_valid_ff;
      overflow_in   = overflow_ff;
      result        = '0;
      result_valid  = 1'b0;
      token_next    = token_ff;

      if (req_fire) begin
         unique case (phase_ff)
            gga_pkg::PHASE_ID: begin
               if (c == gga_pkg::CHAR_COMMA) begin
                  if (id_match_ff && id_pos_ff == 3'(gga_pkg::ID_CHARS)) begin
                     phase_in      = gga_pkg::PHASE_MSG;
                     after_sep_in  = 1'b1;
                     token_in      = '0;
                     msg_len_in    = '0;
                     hemi_len_in   = '0;
                     hemi_valid_in = 1'b0;
                     overflow_in   = 1'b0;
                  end else begin
                     phase_in = gga_pkg::PHASE_HUNT;
                  end
                  id_pos_in   = '0;
                  id_match_in = 1'b1;
               end else if (id_pos_ff >= 3'(gga_pkg::ID_CHARS)) begin
                  id_match_in = 1'b0;
               end else begin
                  if (c != id_char) begin
                     id_match_in = 1'b0;
                  end
                  id_pos_in = id_pos_ff + 3'd1;
               end
            end
            gga_pkg::PHASE_MSG: begin
               if (c == gga_pkg::CHAR_NEWLINE) begin
                  result.end_of_sentence = 1'b1;
                  result.position_fixed  = (hemi_len_ff == 2'd1) && hemi_valid_ff;
                  result.overflowed      = overflow_ff;
                  result_valid           = 1'b1;
                  phase_in      = gga_pkg::PHASE_HUNT;
                  id_pos_in     = '0;
                  id_match_in   = 1'b1;
                  after_sep_in  = 1'b1;
                  token_in      = '0;
                  msg_len_in    = '0;
                  hemi_len_in   = '0;
                  hemi_valid_in = 1'b0;
                  overflow_in   = 1'b0;
               end else if (msg_len_ff >= LEN_CAP) begin
                  overflow_in = 1'b1;
               end else begin
                  msg_len_in = msg_len_ff + LEN_W'(1);
                  if (c == gga_pkg::CHAR_COMMA) begin
                     after_sep_in = 1'b1;
                  end else begin
                     if (after_sep_ff) begin
                        if (token_ff < gga_pkg::TOKEN_MAX) begin
                           token_next = token_ff + 3'd1;
                        end
                        after_sep_in = 1'b0;
                     end
                     token_in = token_next;
                     if (token_next == gga_pkg::TOKEN_LAT_HEMI) begin
                        if (hemi_len_ff == 2'd0) begin
                           hemi_valid_in = (c == gga_pkg::CHAR_NORTH) ||
                                           (c == gga_pkg::CHAR_SOUTH);
                        end
                        if (hemi_len_ff < 2'd2) begin
                           hemi_len_in = hemi_len_ff + 2'd1;
                        end
                     end
                     if (token_next >= gga_pkg::TOKEN_LATITUDE &&
                         token_next <= gga_pkg::TOKEN_LON_HEMI) begin
                        result.out_byte  = c;
                        result.out_field = 2'(token_next - gga_pkg::TOKEN_LATITUDE);
                        result_valid     = 1'b1;
                     end
                  end
               end
            end
            default: begin
               phase_in = gga_pkg::PHASE_HUNT;
               if (c == gga_pkg::CHAR_DOLLAR) begin
                  phase_in    = gga_pkg::PHASE_ID;
                  id_pos_in   = '0;
                  id_match_in = 1'b1;
               end
            end
         endcase
      end
   end

   // Result register with one skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_fire) begin
         out_in        = skid_ff;
         out_valid_in  = skid_valid_ff;
         skid_valid_in = 1'b0;
      end
      if (result_valid) begin
         if (!out_valid_ff || rsp_fire) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sentence_id_ff <= gga_pkg::SENTENCE_ID_RESET;
         phase_ff       <= gga_pkg::PHASE_HUNT;
         id_pos_ff      <= '0;
         id_match_ff    <= 1'b1;
         after_sep_ff   <= 1'b1;
         token_ff       <= '0;
         msg_len_ff     <= '0;
         hemi_len_ff    <= '0;
         hemi_valid_ff  <= 1'b0;
         overflow_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sentence_id_ff <= csr_wr_data;
         end
         phase_ff      <= phase_in;
         id_pos_ff     <= id_pos_in;
         id_match_ff   <= id_match_in;
         after_sep_ff  <= after_sep_in;
         token_ff      <= token_in;
         msg_len_ff    <= msg_len_in;
         hemi_len_ff   <= hemi_len_in;
         hemi_valid_ff <= hemi_valid_in;
         overflow_ff   <= overflow_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.overflowed, out_ff.position_fixed, out_ff.out_byte};
   assign rsp_tuser  = out_ff.out_field;
   assign rsp_tlast  = out_ff.end_of_sentence;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register is empty");

   a_len_capped: assert property (@(posedge clock) disable iff (reset)
      msg_len_ff <= LEN_CAP)
      else $error("message length exceeds cap");

   a_token_outside_msg: assert property (@(posedge clock) disable iff (reset)
      phase_ff != gga_pkg::PHASE_MSG |-> token_ff == 3'd0)
      else $error("token count not cleared outside a message");

   a_end_item_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == 8'd0 && rsp_tuser == 2'd0)
      else $error("end item carries a character");

   a_char_item_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[9:8] == 2'd0)
      else $error("character item carries end flags");
`endif

endmodule

`default_nettype wire
